FILE: hdl/gds_pkg.sv
// ---------------------------------------------------------------------------
// gds_pkg - shared types, codes and calendar helpers
// Word layouts, command and status codes, and the leap-year and month-length
// functions used by the front end and the stepping engine.
// ---------------------------------------------------------------------------
package gds_pkg;

  // field widths
  localparam int CMD_W  = 3;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 15;
  localparam int CNT_W  = 15;
  localparam int ST_W   = 2;
  // remaining days for the week command: 7 * 32767 fits in 18 bits
  localparam int REM_W  = 18;
  // ten times the count, for the decade underflow check
  localparam int DEC_W  = 19;

  localparam int COUNT_MAX_DEF = 32767;

  // job queue between front end and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_DAYS    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WEEKS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MONTHS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_YEARS   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DECADES = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  // calendar constants
  localparam logic [MON_W-1:0]  MON_JAN   = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB   = 4'd2;
  localparam logic [MON_W-1:0]  MON_DEC   = 4'd12;
  localparam logic [DAY_W-1:0]  DAY_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0]  DAY_FEB   = 5'd28;
  localparam logic [YEAR_W-1:0] YEAR_MIN  = 15'd1;
  localparam logic [YEAR_W-1:0] DECADE    = 15'd10;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // y / 25 by reciprocal: exact for all 15-bit years
  localparam logic [15:0] RECIP_25 = 16'd41944;
  localparam int          RECIP_SH = 20;

  // engine work modes
  typedef enum logic [1:0] {
    MD_DONE,
    MD_DAYS,
    MD_MONTHS,
    MD_DECADES
  } mode_t;

  // engine states
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DAY_W-1:0]  in_day;
    logic [MON_W-1:0]  in_month;
    logic [YEAR_W-1:0] in_year;
    logic [CNT_W-1:0]  unit_count;
  } in_word_t;

  typedef struct packed {
    logic [DAY_W-1:0]  out_day;
    logic [MON_W-1:0]  out_month;
    logic [YEAR_W-1:0] out_year;
    logic [ST_W-1:0]   status;
  } out_word_t;

  // classified job handed from front end to engine
  typedef struct packed {
    mode_t             mode;
    logic [ST_W-1:0]   status;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [REM_W-1:0]  rem;
    logic [DAY_W-1:0]  orig_day;
    logic [MON_W-1:0]  orig_month;
    logic [YEAR_W-1:0] orig_year;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // divisible by 4 and not 100, or by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [30:0]       prod;
    logic [10:0]       q25;
    logic [YEAR_W-1:0] r25;
    logic              by4;
    logic              by25;
    prod = 31'(y) * 31'(RECIP_25);
    q25  = prod[30:RECIP_SH];
    r25  = y - YEAR_W'(YEAR_W'(q25) * YEAR_W'(25));
    by4  = (y[1:0] == 2'd0);
    by25 = (r25 == '0);
    return (by4 && !by25) || ((y[3:0] == 4'd0) && by25);
  endfunction

  // month length, zero for a month code outside the calendar
  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                   input logic leap);
    logic [MON_W-1:0] idx;
    idx = m - MON_JAN;
    if (m == MON_FEB) begin
      return leap ? DAY_LEAP : DAY_FEB;
    end else if ((m >= MON_JAN) && (m <= MON_DEC)) begin
      return MONTH_LEN[idx];
    end else begin
      return '0;
    end
  endfunction

endpackage

FILE: hdl/gds_front.sv
// ---------------------------------------------------------------------------
// gds_front - input classifier
// Validates the date, saturates the count and turns each command into a job
// for the stepping engine; invalid dates and year and decade underflow are caught here.
// ---------------------------------------------------------------------------
module gds_front #(
  parameter int unsigned COUNT_MAX = gds_pkg::COUNT_MAX_DEF
) (
  input  gds_pkg::in_word_t in_word,
  output gds_pkg::job_t     job
);

  logic [gds_pkg::CNT_W-1:0]  cnt;
  logic                       leap0;
  logic [gds_pkg::DAY_W-1:0]  dim0;
  logic                       date_ok;
  logic [gds_pkg::DEC_W-1:0]  ten_cnt;
  logic [gds_pkg::REM_W-1:0]  cnt_rem;

  // saturate the count
  always_comb begin
    if (17'(in_word.unit_count) > 17'(COUNT_MAX)) begin
      cnt = gds_pkg::CNT_W'(COUNT_MAX);
    end else begin
      cnt = in_word.unit_count;
    end
  end

  // date check, month length is zero for a bad month
  assign leap0   = gds_pkg::is_leap(in_word.in_year);
  assign dim0    = gds_pkg::month_days(in_word.in_month, leap0);
  assign date_ok = (in_word.in_year != '0) && (in_word.in_day != '0) &&
                   (in_word.in_day <= dim0);

  assign ten_cnt = (gds_pkg::DEC_W'(cnt) << 3) + (gds_pkg::DEC_W'(cnt) << 1);
  assign cnt_rem = gds_pkg::REM_W'(cnt);

  // classify the command
  always_comb begin
    job.mode       = gds_pkg::MD_DONE;
    job.status     = gds_pkg::ST_OK;
    job.day        = in_word.in_day;
    job.month      = in_word.in_month;
    job.year       = in_word.in_year;
    job.rem        = '0;
    job.orig_day   = in_word.in_day;
    job.orig_month = in_word.in_month;
    job.orig_year  = in_word.in_year;
    if (!date_ok) begin
      job.status = gds_pkg::ST_INVALID;
    end else begin
      case (in_word.command)
        gds_pkg::CMD_DAYS: begin
          job.mode = gds_pkg::MD_DAYS;
          job.rem  = cnt_rem;
        end
        gds_pkg::CMD_WEEKS: begin
          job.mode = gds_pkg::MD_DAYS;
          job.rem  = (cnt_rem << 3) - cnt_rem;
        end
        gds_pkg::CMD_MONTHS: begin
          job.mode = gds_pkg::MD_MONTHS;
          job.rem  = cnt_rem;
        end
        gds_pkg::CMD_YEARS: begin
          // single landing year, checked once by the decade step
          if (cnt >= in_word.in_year) begin
            job.status = gds_pkg::ST_UNDERFLOW;
          end else begin
            job.mode = gds_pkg::MD_DECADES;
            job.year = in_word.in_year - cnt;
          end
        end
        gds_pkg::CMD_DECADES: begin
          if (ten_cnt >= gds_pkg::DEC_W'(in_word.in_year)) begin
            job.status = gds_pkg::ST_UNDERFLOW;
          end else begin
            job.mode = gds_pkg::MD_DECADES;
            job.rem  = cnt_rem;
          end
        end
        default: begin
          job.mode = gds_pkg::MD_DONE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/gds_queue.sv
// ---------------------------------------------------------------------------
// gds_queue - job queue
// Short register FIFO that decouples the classifier from the stepping engine.
// ---------------------------------------------------------------------------
module gds_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gds_pkg::job_t     wr_job,
  input  logic              pop,
  output gds_pkg::job_t     rd_job,
  output gds_pkg::q_stat_t  stat
);

  gds_pkg::job_t                 entry_r [gds_pkg::QUEUE_DEPTH];
  logic [gds_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [gds_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [gds_pkg::QCNT_W-1:0]    count_r,  count_nxt;
  logic                          do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == gds_pkg::QCNT_W'(gds_pkg::QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == gds_pkg::QPTR_W'(gds_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == gds_pkg::QPTR_W'(gds_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

FILE: hdl/gds_back.sv
// ---------------------------------------------------------------------------
// gds_back - stepping engine
// Pops jobs and walks the date back one month, month-chunk of days or decade
// per cycle, then drives one result word for a single cycle.
// ---------------------------------------------------------------------------
module gds_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gds_pkg::q_stat_t   q_stat,
  input  gds_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  output gds_pkg::out_word_t out_word
);

  gds_pkg::bk_state_t           state_r,  state_nxt;
  gds_pkg::mode_t               mode_r,   mode_nxt;
  logic [gds_pkg::ST_W-1:0]     code_r,   code_nxt;
  logic [gds_pkg::DAY_W-1:0]    day_r,    day_nxt;
  logic [gds_pkg::MON_W-1:0]    mon_r,    mon_nxt;
  logic [gds_pkg::YEAR_W-1:0]   year_r,   year_nxt;
  logic [gds_pkg::REM_W-1:0]    rem_r,    rem_nxt;
  logic [gds_pkg::DAY_W-1:0]    oday_r,   oday_nxt;
  logic [gds_pkg::MON_W-1:0]    omon_r,   omon_nxt;
  logic [gds_pkg::YEAR_W-1:0]   oyear_r,  oyear_nxt;
  logic                         valid_r,  valid_nxt;
  gds_pkg::out_word_t           word_r,   word_nxt;

  logic                         leap_cur;
  logic [gds_pkg::MON_W-1:0]    m_prev;
  logic [gds_pkg::YEAR_W-1:0]   y_prev;
  logic [gds_pkg::DAY_W-1:0]    dim_prev;
  logic                         at_floor;
  logic [gds_pkg::DAY_W-1:0]    d_dec;
  logic                         fin;
  logic [gds_pkg::ST_W-1:0]     fin_st;
  logic [gds_pkg::DAY_W-1:0]    fin_day;

  // previous month of the working date; feb never crosses a year
  assign leap_cur = gds_pkg::is_leap(year_r);
  assign m_prev   = (mon_r == gds_pkg::MON_JAN) ? gds_pkg::MON_DEC : mon_r - 1'b1;
  assign y_prev   = (mon_r == gds_pkg::MON_JAN) ? year_r - 1'b1 : year_r;
  assign dim_prev = gds_pkg::month_days(m_prev, leap_cur);
  assign at_floor = (mon_r == gds_pkg::MON_JAN) && (year_r == gds_pkg::YEAR_MIN);

  // feb 29 becomes feb 28 on a non-leap landing year
  assign d_dec = ((mon_r == gds_pkg::MON_FEB) && (day_r == gds_pkg::DAY_LEAP) &&
                  !leap_cur) ? gds_pkg::DAY_FEB : day_r;

  // next state and step logic
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    code_nxt  = code_r;
    day_nxt   = day_r;
    mon_nxt   = mon_r;
    year_nxt  = year_r;
    rem_nxt   = rem_r;
    oday_nxt  = oday_r;
    omon_nxt  = omon_r;
    oyear_nxt = oyear_r;
    valid_nxt = 1'b0;
    word_nxt  = word_r;
    q_pop     = 1'b0;
    fin       = 1'b0;
    fin_st    = gds_pkg::ST_OK;
    fin_day   = day_r;
    case (state_r)
      gds_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          mode_nxt  = q_job.mode;
          code_nxt  = q_job.status;
          day_nxt   = q_job.day;
          mon_nxt   = q_job.month;
          year_nxt  = q_job.year;
          rem_nxt   = q_job.rem;
          oday_nxt  = q_job.orig_day;
          omon_nxt  = q_job.orig_month;
          oyear_nxt = q_job.orig_year;
          state_nxt = gds_pkg::BK_RUN;
        end
      end
      gds_pkg::BK_RUN: begin
        case (mode_r)
          gds_pkg::MD_DAYS: begin
            if (rem_r == '0) begin
              fin = 1'b1;
            end else if (rem_r < gds_pkg::REM_W'(day_r)) begin
              day_nxt = day_r - gds_pkg::DAY_W'(rem_r);
              rem_nxt = '0;
            end else if (at_floor) begin
              fin    = 1'b1;
              fin_st = gds_pkg::ST_UNDERFLOW;
            end else begin
              rem_nxt  = rem_r - gds_pkg::REM_W'(day_r);
              mon_nxt  = m_prev;
              year_nxt = y_prev;
              day_nxt  = dim_prev;
            end
          end
          gds_pkg::MD_MONTHS: begin
            if (rem_r == '0) begin
              fin = 1'b1;
            end else if (at_floor) begin
              fin    = 1'b1;
              fin_st = gds_pkg::ST_UNDERFLOW;
            end else begin
              rem_nxt  = rem_r - 1'b1;
              mon_nxt  = m_prev;
              year_nxt = y_prev;
              day_nxt  = (day_r > dim_prev) ? dim_prev : day_r;
            end
          end
          gds_pkg::MD_DECADES: begin
            day_nxt = d_dec;
            if (rem_r == '0) begin
              fin     = 1'b1;
              fin_day = d_dec;
            end else begin
              rem_nxt  = rem_r - 1'b1;
              year_nxt = year_r - gds_pkg::DECADE;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = code_r;
          end
        endcase
        // result word, echo the input date on any error
        if (fin) begin
          valid_nxt       = 1'b1;
          state_nxt       = gds_pkg::BK_IDLE;
          word_nxt.status = fin_st;
          if (fin_st == gds_pkg::ST_OK) begin
            word_nxt.out_day   = fin_day;
            word_nxt.out_month = mon_r;
            word_nxt.out_year  = year_r;
          end else begin
            word_nxt.out_day   = oday_r;
            word_nxt.out_month = omon_r;
            word_nxt.out_year  = oyear_r;
          end
        end
      end
      default: begin
        state_nxt = gds_pkg::BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gds_pkg::BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // working date and result payload
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    code_r  <= code_nxt;
    day_r   <= day_nxt;
    mon_r   <= mon_nxt;
    year_r  <= year_nxt;
    rem_r   <= rem_nxt;
    oday_r  <= oday_nxt;
    omon_r  <= omon_nxt;
    oyear_r <= oyear_nxt;
    word_r  <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

FILE: hdl/gregorian_date_subtract_unit.sv
// ---------------------------------------------------------------------------
// gregorian_date_subtract_unit - moves a calendar date back by a unit count
// Classifier, two-entry job queue and stepping engine; one result per word.
//
//   channel   ports                     handshake
//   input     start, busy, in_word      taken when start && !busy
//   result    out_valid, out_word       one-cycle strobe, never stalled
//
// Invalid dates, unknown commands, underflow caught up front and years
// commands go straight to the result once popped; months and decades take
// one engine step per unit; days and weeks take one step per month boundary
// crossed, and one more when the walk ends inside a month.
// Reset clears the queue and engine control; payload registers are not reset.
// busy rises only when the queue holds two words behind the engine.
// ---------------------------------------------------------------------------
module gregorian_date_subtract_unit #(
  parameter int unsigned COUNT_MAX = gds_pkg::COUNT_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gds_pkg::in_word_t  in_word,
  output logic               out_valid,
  output gds_pkg::out_word_t out_word
);

  gds_pkg::job_t    front_job;
  gds_pkg::job_t    q_job;
  gds_pkg::q_stat_t q_stat;
  logic             q_pop;
  logic             push;

  assign busy = q_stat.full;
  assign push = start && !busy;

  // classify the incoming word
  gds_front #(
    .COUNT_MAX (COUNT_MAX)
  ) u_front (
    .in_word (in_word),
    .job     (front_job)
  );

  // decoupling queue
  gds_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (front_job),
    .pop    (q_pop),
    .rd_job (q_job),
    .stat   (q_stat)
  );

  // stepping engine
  gds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // a result strobe lasts one cycle since the engine returns to idle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // no reserved status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == gds_pkg::ST_OK ||
                   out_word.status == gds_pkg::ST_INVALID ||
                   out_word.status == gds_pkg::ST_UNDERFLOW))
    else $error("reserved status code on result");

  // a good result is a real calendar day
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == gds_pkg::ST_OK) |->
      (out_word.out_month >= gds_pkg::MON_JAN && out_word.out_month <= gds_pkg::MON_DEC &&
       out_word.out_day != '0 && out_word.out_year != '0))
    else $error("ok result is not a calendar date");

  // the queue becomes full only after a push
  a_busy_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy) && $past(rst_n)) |-> $past(push))
    else $error("queue filled without a push");

endmodule
